FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file of the wipe pixel selector.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define WPS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, held off while reset is asserted.
`define WPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/wps_pkg.sv
// Shared types, codes and helpers of the wipe pixel selector.
// No dependencies; the design modules and channel interfaces import it.
package wps_pkg;

	localparam int PIX_W      = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int SIZE_W     = 14;
	localparam int FRAC_W     = 17;
	localparam int SLOPE_W    = 32;
	localparam int RAD_W      = 13;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_CNT_W = 3;

	localparam logic [FRAC_W-1:0] FRAC_ONE      = 17'd65536;
	// 0.999 in Q1.16, rounded up
	localparam logic [FRAC_W-1:0] FRAC_NEAR_ONE = 17'd65471;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WIPE_MODE     = 3'd0,
		CFG_SWAP_SOURCES  = 3'd1,
		CFG_IMAGE_WIDTH   = 3'd2,
		CFG_IMAGE_HEIGHT  = 3'd3,
		CFG_WIPE_FRACTION = 3'd4,
		CFG_DIAG_SLOPE    = 3'd5,
		CFG_CIRCLE_RADIUS = 3'd6
	} cfg_reg_t;

	typedef enum logic [2:0] {
		MODE_VERTICAL   = 3'd0,
		MODE_HORIZONTAL = 3'd1,
		MODE_DIAGONAL   = 3'd2,
		MODE_SOLID      = 3'd3,
		MODE_CIRCLE     = 3'd4,
		MODE_CHECKER    = 3'd5
	} wipe_mode_t;

	typedef enum logic [1:0] {
		SPAN_OUTSIDE = 2'd0,
		SPAN_INSIDE  = 2'd1,
		SPAN_WHOLE   = 2'd2
	} span_kind_t;

	typedef enum logic [1:0] {
		FS_SETTLE  = 2'd0,
		FS_DIV_COL = 2'd1,
		FS_DIV_ROW = 2'd2,
		FS_RUN     = 2'd3
	} front_state_t;

	typedef enum logic [2:0] {
		SB_CLEAR = 3'd0,
		SB_STEP  = 3'd1,
		SB_MARK  = 3'd2,
		SB_ADV   = 3'd3,
		SB_DONE  = 3'd4
	} build_state_t;

	// Configuration as the datapath sees it: clamped sizes and split points.
	typedef struct packed {
		logic [2:0]         mode;
		logic               swap;
		logic [SIZE_W-1:0]  w_eff;
		logic [SIZE_W-1:0]  h_eff;
		logic [SIZE_W-1:0]  n_v;
		logic [SIZE_W-1:0]  n_h;
		logic [SIZE_W-1:0]  cell_sz;
		logic               diag_off;
		logic [SLOPE_W-1:0] slope;
		logic [RAD_W-1:0]   radius;
	} cfg_view_t;

	// Width of one queued item between the front and back parts.
	function automatic int entry_w(input int mw, input int mh);
		int cw;
		int rw;
		cw = $clog2(mw);
		rw = $clog2(mh);
		return 2 * PIX_W + cw + rw + 2 + (2 + 2 * cw) + (rw + 16);
	endfunction

	// Step a checker cell counter; top bit tells that a cell boundary passed.
	function automatic logic [SIZE_W:0] cell_step(input logic [SIZE_W-1:0] cnt,
		input logic [SIZE_W-1:0] cell_sz);
		logic [SIZE_W:0] nxt;
		nxt = {1'b0, cnt} + {{SIZE_W{1'b0}}, 1'b1};
		if (nxt >= {1'b0, cell_sz}) begin
			return {1'b1, {SIZE_W{1'b0}}};
		end
		return {1'b0, nxt[SIZE_W-1:0]};
	endfunction

endpackage

FILE: rtl/wps_in_if.sv
// Input channel of the wipe pixel selector: one pixel pair per item.
// Depends on wps_pkg.
interface wps_in_if;
	import wps_pkg::*;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_one;
	logic [PIX_W-1:0] pixel_two;
	modport source(output valid, pixel_one, pixel_two, input ready);
	modport sink(input valid, pixel_one, pixel_two, output ready);
endinterface

FILE: rtl/wps_out_if.sv
// Output channel of the wipe pixel selector: one selected pixel per item.
// Depends on wps_pkg.
interface wps_out_if;
	import wps_pkg::*;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_out;
	logic             from_second;
	logic             written;
	logic             frame_end;
	modport source(output valid, pixel_out, from_second, written, frame_end, input ready);
	modport sink(input valid, pixel_out, from_second, written, frame_end, output ready);
endinterface

FILE: rtl/wps_cfg_if.sv
// Register write channel of the wipe pixel selector.
// Depends on wps_pkg.
interface wps_cfg_if;
	import wps_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

FILE: rtl/wps_span.sv
// Circle span table: per-row span memory and the octant stepper that fills it.
// Depends on wps_pkg.
module wps_span #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  wps_pkg::cfg_view_t                     cv,
	input  logic                                   rebuild,
	input  logic [$clog2(MAX_HEIGHT)-1:0]          raddr,
	output logic [2+2*$clog2(MAX_WIDTH)-1:0]       rdata,
	output logic                                   ready
);
	import wps_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int HW = $clog2(MAX_HEIGHT);
	localparam int EW = 2 + 2 * CW;

	build_state_t      state_q, state_d;
	logic [HW-1:0]     addr_q;
	logic signed [15:0] x_q, y_q, err_q;
	logic              ychg_q;
	logic [1:0]        mk_q;

	logic [EW-1:0]     mem [MAX_HEIGHT];
	logic [EW-1:0]     rdata_q;

	logic              we;
	logic [HW-1:0]     waddr;
	logic [EW-1:0]     wdata;

	logic signed [15:0] w_s, h_s, cx, cy;
	logic signed [15:0] row, lo, hi, e1;
	logic              en;

	assign w_s = signed'(16'(cv.w_eff));
	assign h_s = signed'(16'(cv.h_eff));
	assign cx  = w_s >>> 1;
	assign cy  = h_s >>> 1;
	assign e1  = err_q - x_q;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			SB_CLEAR: if (addr_q == HW'(MAX_HEIGHT - 1)) state_d = SB_STEP;
			SB_STEP:  state_d = (x_q <= y_q) ? SB_MARK : SB_DONE;
			SB_MARK:  if (mk_q == 2'd3) state_d = SB_ADV;
			SB_ADV:   state_d = SB_STEP;
			SB_DONE:  state_d = SB_DONE;
			default:  state_d = SB_CLEAR;
		endcase
		if (rebuild) state_d = SB_CLEAR;
	end

	// Pick the row mark of this sub-step and form the memory write
	always_comb begin
		en  = 1'b0;
		row = cy - y_q;
		lo  = cx - x_q;
		hi  = cx + x_q;
		case (mk_q)
			2'd0: begin
				row = cy - y_q;
				en  = ychg_q && (row >= 0);
			end
			2'd1: begin
				row = cy + y_q;
				en  = ychg_q && (row < h_s);
			end
			2'd2: begin
				row = cy - x_q;
				lo  = cx - y_q;
				hi  = cx + y_q;
				en  = row >= 0;
			end
			2'd3: begin
				row = cy + x_q;
				lo  = cx - y_q;
				hi  = cx + y_q;
				en  = row < h_s;
			end
			default: en = 1'b0;
		endcase

		we    = 1'b0;
		waddr = addr_q;
		wdata = {SPAN_OUTSIDE, {(2*CW){1'b0}}};
		case (state_q)
			SB_CLEAR: we = 1'b1;
			SB_MARK: begin
				we    = en;
				waddr = row[HW-1:0];
				if (lo < 0 || hi >= w_s) begin
					wdata = {SPAN_WHOLE, {(2*CW){1'b0}}};
				end else begin
					wdata = {SPAN_INSIDE, lo[CW-1:0], hi[CW-1:0]};
				end
			end
			default: we = 1'b0;
		endcase
		ready = (state_q == SB_DONE);
	end

	// Control registers of the stepper
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SB_CLEAR;
			addr_q  <= '0;
			mk_q    <= '0;
		end else begin
			state_q <= state_d;
			if (rebuild) begin
				addr_q <= '0;
			end else if (state_q == SB_CLEAR) begin
				addr_q <= addr_q + HW'(1);
			end
			if (state_q == SB_MARK) mk_q <= mk_q + 2'd1;
			else mk_q <= 2'd0;
		end
	end

	// Octant walk: start at y = R, err = R/2, advance x once per step
	always_ff @(posedge clk) begin
		if (state_q == SB_CLEAR) begin
			x_q    <= '0;
			y_q    <= signed'(16'(cv.radius));
			err_q  <= signed'(16'(cv.radius >> 1));
			ychg_q <= 1'b1;
		end else if (state_q == SB_ADV) begin
			x_q <= x_q + 16'sd1;
			if (e1 < 0) begin
				err_q  <= e1 + y_q;
				y_q    <= y_q - 16'sd1;
				ychg_q <= 1'b1;
			end else begin
				err_q  <= e1;
				ychg_q <= 1'b0;
			end
		end
	end

	// Span memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/wps_fifo.sv
// Short queue that decouples the classifying front from the selecting back.
// Depends on wps_pkg.
module wps_fifo #(
	parameter int WIDTH = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	input  logic [WIDTH-1:0]               wdata,
	input  logic                           pop,
	output logic [WIDTH-1:0]               rdata,
	output logic [wps_pkg::FIFO_CNT_W-1:0] count
);
	import wps_pkg::*;

	localparam int PW = $clog2(FIFO_DEPTH);

	logic [WIDTH-1:0]      slot_q [FIFO_DEPTH];
	logic [PW-1:0]         wr_q, rd_q;
	logic [FIFO_CNT_W-1:0] count_q;

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + PW'(1);
			if (pop) rd_q <= rd_q + PW'(1);
			count_q <= count_q + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
		end
	end

	// Hold item payloads
	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= wdata;
	end

	assign rdata = slot_q[rd_q];
	assign count = count_q;

endmodule

FILE: rtl/wps_front.sv
// Front part: register file, raster and checker counters, item classification.
// Depends on wps_pkg and the channel interfaces.
module wps_front #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                                               clk,
	input  logic                                               arst_n,
	wps_cfg_if.sink                                            cfg,
	wps_in_if.sink                                             src,
	output wps_pkg::cfg_view_t                                 cv,
	output logic                                               span_rebuild,
	input  logic                                               span_ready,
	output logic [$clog2(MAX_HEIGHT)-1:0]                      span_raddr,
	input  logic [2+2*$clog2(MAX_WIDTH)-1:0]                   span_rdata,
	input  logic [wps_pkg::FIFO_CNT_W-1:0]                     fifo_count,
	output logic                                               fifo_push,
	output logic [wps_pkg::entry_w(MAX_WIDTH, MAX_HEIGHT)-1:0] fifo_wdata
);
	import wps_pkg::*;

	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int RW   = $clog2(MAX_HEIGHT);
	localparam int DW   = (CW > RW) ? CW : RW;
	localparam int IT_W = $clog2(DW + 1);
	localparam int PW   = RW + SLOPE_W;

	// Raw registers
	logic [2:0]         mode_q;
	logic               swap_q;
	logic [12:0]        width_q, height_q;
	logic [FRAC_W-1:0]  frac_q;
	logic [SLOPE_W-1:0] slope_q;
	logic [RAD_W-1:0]   radius_q;
	logic               cfg_wr;

	cfg_view_t          dv_q, dv_d;
	logic [FRAC_W-1:0]  f_eff;
	logic [30:0]        prod_v, prod_h;

	// Counters
	logic [CW-1:0]      c_q;
	logic [RW-1:0]      r_q;
	logic [SIZE_W-1:0]  ccnt_q, rcnt_q;
	logic               cpar_q, rpar_q;

	// Prep sequencer and divider
	front_state_t       state_q, state_d;
	logic [DW-1:0]      dvd_q;
	logic [SIZE_W-1:0]  rem_q, rem_n;
	logic [SIZE_W:0]    trial;
	logic               ge;
	logic [IT_W-1:0]    it_q;
	logic               div_last;

	// Item path
	logic               accept, last_col, last_row;
	logic [SIZE_W:0]    cstep, rstep;
	logic               s1_valid_q;
	logic [PIX_W-1:0]   p1_s1, p2_s1;
	logic [CW-1:0]      c_s1;
	logic [RW-1:0]      r_s1;
	logic               par_s1, fe_s1;
	logic [PW-1:0]      dprod;

	assign cfg.ready = 1'b1;
	assign cfg_wr    = cfg.valid && cfg.ready;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= '0;
			swap_q   <= 1'b0;
			width_q  <= 13'd1;
			height_q <= 13'd1;
			frac_q   <= '0;
			slope_q  <= '0;
			radius_q <= '0;
		end else if (cfg_wr) begin
			case (cfg.index)
				CFG_WIPE_MODE:     mode_q   <= cfg.data[2:0];
				CFG_SWAP_SOURCES:  swap_q   <= cfg.data[0];
				CFG_IMAGE_WIDTH:   width_q  <= cfg.data[12:0];
				CFG_IMAGE_HEIGHT:  height_q <= cfg.data[12:0];
				CFG_WIPE_FRACTION: frac_q   <= cfg.data[FRAC_W-1:0];
				CFG_DIAG_SLOPE:    slope_q  <= cfg.data[SLOPE_W-1:0];
				CFG_CIRCLE_RADIUS: radius_q <= cfg.data[RAD_W-1:0];
				default: ;
			endcase
		end
	end

	assign span_rebuild = cfg_wr && (cfg.index == CFG_WIPE_MODE ||
		cfg.index == CFG_IMAGE_WIDTH || cfg.index == CFG_IMAGE_HEIGHT ||
		cfg.index == CFG_CIRCLE_RADIUS);

	// Clamp sizes and fraction, form split points and checker cell size
	always_comb begin
		dv_d        = '0;
		dv_d.mode   = mode_q;
		dv_d.swap   = swap_q;
		dv_d.slope  = slope_q;
		dv_d.radius = radius_q;
		if (width_q == '0) dv_d.w_eff = SIZE_W'(1);
		else if (32'(width_q) > 32'(MAX_WIDTH)) dv_d.w_eff = SIZE_W'(MAX_WIDTH);
		else dv_d.w_eff = SIZE_W'(width_q);
		if (height_q == '0) dv_d.h_eff = SIZE_W'(1);
		else if (32'(height_q) > 32'(MAX_HEIGHT)) dv_d.h_eff = SIZE_W'(MAX_HEIGHT);
		else dv_d.h_eff = SIZE_W'(height_q);
		f_eff  = (frac_q > FRAC_ONE) ? FRAC_ONE : frac_q;
		prod_v = 31'(f_eff) * 31'(dv_d.w_eff);
		prod_h = 31'(f_eff) * 31'(dv_d.h_eff);
		dv_d.n_v      = prod_v[16 +: SIZE_W];
		dv_d.n_h      = prod_h[16 +: SIZE_W];
		dv_d.cell_sz  = (dv_d.n_v == '0) ? SIZE_W'(1) : dv_d.n_v;
		dv_d.diag_off = (f_eff == '0) || (f_eff >= FRAC_NEAR_ONE);
	end

	always_ff @(posedge clk) begin
		dv_q <= dv_d;
	end

	assign cv = dv_q;

	// One restoring divider step against the cell size
	always_comb begin
		trial    = {rem_q, dvd_q[DW-1]};
		ge       = trial >= {1'b0, dv_q.cell_sz};
		rem_n    = ge ? SIZE_W'(trial - {1'b0, dv_q.cell_sz}) : SIZE_W'(trial);
		div_last = (it_q == IT_W'(DW - 1));
	end

	// Next state: realign checker cells after every register write
	always_comb begin
		state_d = state_q;
		case (state_q)
			FS_SETTLE:  state_d = FS_DIV_COL;
			FS_DIV_COL: if (div_last) state_d = FS_DIV_ROW;
			FS_DIV_ROW: if (div_last) state_d = FS_RUN;
			FS_RUN:     state_d = FS_RUN;
			default:    state_d = FS_SETTLE;
		endcase
		if (cfg_wr) state_d = FS_SETTLE;
	end

	// Outputs: accept only with table built and queue room for in-flight items
	always_comb begin
		src.ready = (state_q == FS_RUN) && span_ready &&
			(32'(fifo_count) + 32'(s1_valid_q) < FIFO_DEPTH);
		accept    = src.valid && src.ready;
		last_col  = 32'(c_q) + 32'd1 >= 32'(dv_q.w_eff);
		last_row  = 32'(r_q) + 32'd1 >= 32'(dv_q.h_eff);
		cstep     = cell_step(ccnt_q, dv_q.cell_sz);
		rstep     = cell_step(rcnt_q, dv_q.cell_sz);
	end

	assign span_raddr = r_q;

	// Raster and checker counters, divider registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FS_SETTLE;
			c_q     <= '0;
			r_q     <= '0;
			ccnt_q  <= '0;
			rcnt_q  <= '0;
			cpar_q  <= 1'b0;
			rpar_q  <= 1'b0;
			dvd_q   <= '0;
			rem_q   <= '0;
			it_q    <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				FS_SETTLE: begin
					dvd_q <= DW'(c_q);
					rem_q <= '0;
					it_q  <= '0;
				end
				FS_DIV_COL: begin
					dvd_q <= dvd_q << 1;
					rem_q <= rem_n;
					it_q  <= it_q + IT_W'(1);
					if (div_last) begin
						ccnt_q <= rem_n;
						cpar_q <= ge;
						dvd_q  <= DW'(r_q);
						rem_q  <= '0;
						it_q   <= '0;
					end
				end
				FS_DIV_ROW: begin
					dvd_q <= dvd_q << 1;
					rem_q <= rem_n;
					it_q  <= it_q + IT_W'(1);
					if (div_last) begin
						rcnt_q <= rem_n;
						rpar_q <= ge;
					end
				end
				FS_RUN: begin
					if (accept) begin
						if (last_col) begin
							c_q    <= '0;
							ccnt_q <= '0;
							cpar_q <= 1'b0;
							if (last_row) begin
								r_q    <= '0;
								rcnt_q <= '0;
								rpar_q <= 1'b0;
							end else begin
								r_q    <= r_q + RW'(1);
								rcnt_q <= rstep[SIZE_W-1:0];
								rpar_q <= rpar_q ^ rstep[SIZE_W];
							end
						end else begin
							c_q    <= c_q + CW'(1);
							ccnt_q <= cstep[SIZE_W-1:0];
							cpar_q <= cpar_q ^ cstep[SIZE_W];
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Stage 1: hold the item while the span row is read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else begin
			s1_valid_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			p1_s1  <= src.pixel_one;
			p2_s1  <= src.pixel_two;
			c_s1   <= c_q;
			r_s1   <= r_q;
			par_s1 <= cpar_q ^ rpar_q;
			fe_s1  <= last_col && last_row;
		end
	end

	// Diagonal split of this row, then push the classified item
	assign dprod      = PW'(r_s1) * PW'(dv_q.slope);
	assign fifo_push  = s1_valid_q;
	assign fifo_wdata = {p1_s1, p2_s1, c_s1, r_s1, par_s1, fe_s1, span_rdata,
		dprod[PW-1:16]};

endmodule

FILE: rtl/wps_back.sv
// Back part: pick the pixel of each queued item and hold it in the output register.
// Depends on wps_pkg and the output channel interface.
module wps_back #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                                               clk,
	input  logic                                               arst_n,
	input  wps_pkg::cfg_view_t                                 cv,
	input  logic [wps_pkg::entry_w(MAX_WIDTH, MAX_HEIGHT)-1:0] fifo_rdata,
	input  logic [wps_pkg::FIFO_CNT_W-1:0]                     fifo_count,
	output logic                                               fifo_pop,
	wps_out_if.source                                          dst
);
	import wps_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int NW = RW + 16;

	logic [PIX_W-1:0] p1, p2, first, second;
	logic [CW-1:0]    c, left, right;
	logic [RW-1:0]    r;
	logic             par, fe, sel, ok;
	logic [1:0]       kind;
	logic [NW-1:0]    nd;

	logic             valid_q;
	logic [PIX_W-1:0] pix_q;
	logic             sec_q, wr_q, fe_q;

	assign {p1, p2, c, r, par, fe, kind, left, right, nd} = fifo_rdata;

	// Wipe pattern test at this raster position
	always_comb begin
		sel = 1'b0;
		ok  = 1'b1;
		case (cv.mode)
			MODE_VERTICAL:   sel = 32'(c) >= 32'(cv.n_v);
			MODE_HORIZONTAL: sel = 32'(r) >= 32'(cv.n_h);
			MODE_DIAGONAL:   sel = !cv.diag_off &&
				((32'(c) >= 32'(cv.w_eff)) || (NW'(c) >= nd));
			MODE_SOLID:      sel = 1'b0;
			MODE_CIRCLE: begin
				if (kind == SPAN_WHOLE) sel = 1'b1;
				else if (kind == SPAN_INSIDE) sel = (c >= left) && (c <= right);
				else sel = 1'b0;
			end
			MODE_CHECKER:    sel = par;
			default:         ok = 1'b0;
		endcase
		first  = cv.swap ? p1 : p2;
		second = cv.swap ? p2 : p1;
	end

	assign fifo_pop = (fifo_count != '0) && (!valid_q || dst.ready);

	// Output register: refill whenever empty or being taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || dst.ready) begin
			valid_q <= fifo_pop;
		end
	end

	always_ff @(posedge clk) begin
		if (fifo_pop) begin
			pix_q <= ok ? (sel ? second : first) : '0;
			sec_q <= ok && sel;
			wr_q  <= ok;
			fe_q  <= fe;
		end
	end

	assign dst.valid       = valid_q;
	assign dst.pixel_out   = pix_q;
	assign dst.from_second = sec_q;
	assign dst.written     = wr_q;
	assign dst.frame_end   = fe_q;

endmodule

FILE: rtl/image_wipe_pixel_selector.sv
// Wipe pixel selector: takes raster-ordered pixel pairs and returns one pixel per pair,
// chosen by the vertical, horizontal, diagonal, solid, circle or checker wipe pattern.
// In steady state one item is taken per clock while the output is taken; its result
// passes through the stage-1 register, the queue and the output register. The front
// stops taking items when the four-entry queue toward the output fills, and while the
// checker cell counters are realigned by the shared bit-serial divider after every
// register write. Writes of mode, width, height or radius also rebuild the circle span
// table: a clearing pass through the span memory, then a test, four row marks and an
// advance per octant step; no item is taken until it completes, and the same rebuild
// runs after reset. Registers are taken on any cycle.
// Depends on wps_pkg, the channel interfaces, wps_front, wps_span, wps_fifo, wps_back.
module image_wipe_pixel_selector #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic     clk,
	input  logic     arst_n,
	wps_cfg_if.sink  cfg,
	wps_in_if.sink   src,
	wps_out_if.source dst
);
	import wps_pkg::*;

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int HW  = $clog2(MAX_HEIGHT);
	localparam int ENW = entry_w(MAX_WIDTH, MAX_HEIGHT);

	cfg_view_t             cv;
	logic                  span_rebuild, span_ready;
	logic [HW-1:0]         span_raddr;
	logic [2+2*CW-1:0]     span_rdata;
	logic                  fifo_push, fifo_pop;
	logic [ENW-1:0]        fifo_wdata, fifo_rdata;
	logic [FIFO_CNT_W-1:0] fifo_count;

	wps_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .src(src), .cv(cv),
		.span_rebuild(span_rebuild), .span_ready(span_ready),
		.span_raddr(span_raddr), .span_rdata(span_rdata),
		.fifo_count(fifo_count), .fifo_push(fifo_push), .fifo_wdata(fifo_wdata)
	);

	wps_span #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_span (
		.clk(clk), .arst_n(arst_n), .cv(cv), .rebuild(span_rebuild),
		.raddr(span_raddr), .rdata(span_rdata), .ready(span_ready)
	);

	wps_fifo #(.WIDTH(ENW)) u_fifo (
		.clk(clk), .arst_n(arst_n), .push(fifo_push), .wdata(fifo_wdata),
		.pop(fifo_pop), .rdata(fifo_rdata), .count(fifo_count)
	);

	wps_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
		.clk(clk), .arst_n(arst_n), .cv(cv), .fifo_rdata(fifo_rdata),
		.fifo_count(fifo_count), .fifo_pop(fifo_pop), .dst(dst)
	);

endmodule

FILE: rtl/wps_checker.sv
// Port-level checks of the wipe pixel selector, bound to the top level.
// Depends on assert_macros.svh and image_wipe_pixel_selector.
`include "assert_macros.svh"

module wps_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] pixel_out,
	input logic        from_second,
	input logic        written
);

	// A waiting result stays offered
	`WPS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")

	// A waiting result keeps its pixel
	`WPS_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(pixel_out), "pixel changed while stalled")

	// Unsupported mode gives a zero pixel from no source
	`WPS_ASSERT_NOW(a_unwritten_zero, clk, arst_n, out_valid && !written, pixel_out == 32'd0 && !from_second, "unwritten result not cleared")

	// Second source only on a written result
	`WPS_ASSERT_NOW(a_second_written, clk, arst_n, out_valid && from_second, written, "second source on unwritten result")

endmodule

bind image_wipe_pixel_selector wps_checker u_wps_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(dst.valid),
	.out_ready(dst.ready),
	.pixel_out(dst.pixel_out),
	.from_second(dst.from_second),
	.written(dst.written)
);
